@@ src/mtm_pkg.sv @@
// Shared types, opcodes and constants of the memory-to-memory machine.
package mtm_pkg;

  localparam int MEM_DEPTH_DEF = 65536;

  localparam logic [7:0] STOP_CODE = 8'h08;

  localparam logic [1:0] OP_WR = 2'd0;
  localparam logic [1:0] OP_RD = 2'd1;
  localparam logic [1:0] OP_EX = 2'd2;

  localparam logic [7:0] OPC_MOV  = 8'h00;
  localparam logic [7:0] OPC_CMP  = 8'h01;
  localparam logic [7:0] OPC_SKIP = 8'h06;
  localparam logic [7:0] OPC_JNZ  = 8'h07;
  localparam logic [7:0] OPC_HLTL = 8'h08;
  localparam logic [7:0] OPC_HLTH = 8'hFB;
  localparam logic [7:0] OPC_FC   = 8'hFC;
  localparam logic [7:0] OPC_FD   = 8'hFD;
  localparam logic [7:0] OPC_FE   = 8'hFE;

  localparam logic [2:0] LEN_MOV   = 3'd5;
  localparam logic [2:0] LEN_CMP   = 3'd7;
  localparam logic [2:0] OPND_LAST = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] mem_addr;
    logic [7:0]  wr_byte;
  } mtm_in_t;

  typedef struct packed {
    logic [7:0]  rd_byte;
    logic [15:0] prog_counter;
    logic        is_halted;
    logic [7:0]  last_opcode;
  } mtm_out_t;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mtm_mreq_t;

  function automatic logic is_stop(input logic [7:0] opc);
    return (opc >= OPC_HLTL) && (opc <= OPC_HLTH);
  endfunction

  // pc advance seen at fetch; operand opcodes give the first operand offset
  function automatic logic [2:0] pc_step(input logic [7:0] opc);
    logic [2:0] s;
    if (opc <= OPC_JNZ) begin
      s = 3'd1;
    end else if (opc <= OPC_HLTH) begin
      s = 3'd0;
    end else if (opc == OPC_FC || opc == OPC_FE) begin
      s = 3'd5;
    end else if (opc == OPC_FD) begin
      s = 3'd7;
    end else begin
      s = 3'd3;
    end
    return s;
  endfunction

endpackage

@@ src/mem_to_mem_vm_step.sv @@
// Top level of the memory-to-memory machine: sequencer, memory and output stage.
//
// Input channel in_valid/in_ready/in_data carries one beat per item: op 0 writes
// wr_byte at mem_addr, op 1 reads mem_addr, op 2 executes the instruction at pc,
// op 3 does nothing. Every item gives one result beat on out_valid/out_ready/
// out_data with the read byte, pc, halt flag and fetched opcode.
// Each memory access of an item takes its turn on the single memory port. An
// execute fetches the opcode; JNZ, MOV and CMP_LT then read six operand bytes
// and their data bytes, and MOV and CMP_LT write one byte. Without operands or
// while halted only the opcode is fetched. The sequencer passes through its idle
// state after each result before it takes the next beat.
// One item is in work at a time; in_ready is high only while the sequencer idles.
// After reset all MEM_DEPTH bytes of memory are swept to the stop code 0x08, one
// byte a cycle, with in_ready low; pc and the halt flag clear at once.
// When the receiver stalls the result waits in the output register; the next
// item is still accepted and worked on, and its result is held in the sequencer
// until the output register frees.
module mem_to_mem_vm_step import mtm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mtm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mtm_out_t out_data
);

  mtm_mreq_t  mreq;
  logic [7:0] rdata;
  logic       res_valid;
  logic       res_ready;
  mtm_out_t   res_data;
  logic       out_valid_r;
  mtm_out_t   out_data_r;

  mtm_ctrl #(.MEM_DEPTH(MEM_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  mtm_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/mtm_mem.sv @@
// Single-port byte memory with address reduction and registered read data.
module mtm_mem import mtm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic      clk,
  input  mtm_mreq_t mreq,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0]    mem_q [MEM_DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] idx;

  // quotient of a 16-bit address by the depth stays below 256
  function automatic logic [AW-1:0] reduce(input logic [15:0] a);
    logic [23:0] r;
    r = 24'(a);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (24'(MEM_DEPTH) << k)) begin
        r = r - (24'(MEM_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign idx = reduce(mreq.addr);

  always_ff @(posedge clk) begin
    if (mreq.en) begin
      if (mreq.we) begin
        mem_q[idx] <= mreq.wdata;
      end else begin
        rdata_r <= mem_q[idx];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/mtm_ctrl.sv @@
// Sequencer: clearing pass, byte access and instruction execution over one port.
module mtm_ctrl import mtm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mtm_in_t    in_data,
  output logic       res_valid,
  input  logic       res_ready,
  output mtm_out_t   res_data,
  output mtm_mreq_t  mreq,
  input  logic [7:0] rdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDW, ST_FETCH, ST_OPND, ST_DATA, ST_DATB, ST_DATC, ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic          halt_r, halt_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [47:0]   opr_r, opr_nxt;
  logic [7:0]    d1_r, d1_nxt;
  logic [7:0]    opc_r, opc_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic [2:0]    offs;
  logic [15:0]   sum;
  logic [15:0]   a1, a2, a3;

  // shared address adder
  assign sum = pc_r + 16'(offs);
  assign a1  = opr_r[15:0];
  assign a2  = opr_r[31:16];
  assign a3  = opr_r[47:32];

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    k_nxt     = k_r;
    opr_nxt   = opr_r;
    d1_nxt    = d1_r;
    opc_nxt   = opc_r;
    rd_nxt    = rd_r;
    offs      = 3'd0;
    mreq      = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = 16'(clr_r);
        mreq.wdata = STOP_CODE;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_nxt  = 8'd0;
          opc_nxt = 8'd0;
          case (in_data.op)
            OP_WR: begin
              mreq.en    = 1'b1;
              mreq.we    = 1'b1;
              mreq.addr  = in_data.mem_addr;
              mreq.wdata = in_data.wr_byte;
              state_nxt  = ST_DONE;
            end
            OP_RD: begin
              mreq.en   = 1'b1;
              mreq.addr = in_data.mem_addr;
              state_nxt = ST_RDW;
            end
            OP_EX: begin
              mreq.en   = 1'b1;
              mreq.addr = pc_r;
              state_nxt = ST_FETCH;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RDW: begin
        rd_nxt    = rdata;
        state_nxt = ST_DONE;
      end
      ST_FETCH: begin
        opc_nxt = rdata;
        offs    = pc_step(rdata);
        if (halt_r) begin
          state_nxt = ST_DONE;
        end else if (rdata == OPC_MOV || rdata == OPC_CMP || rdata == OPC_JNZ) begin
          mreq.en   = 1'b1;
          mreq.addr = sum;
          k_nxt     = 3'd1;
          state_nxt = ST_OPND;
        end else begin
          halt_nxt  = is_stop(rdata);
          pc_nxt    = sum;
          state_nxt = ST_DONE;
        end
      end
      ST_OPND: begin
        opr_nxt = {rdata, opr_r[47:8]};
        offs    = k_r + 3'd1;
        if (k_r == OPND_LAST) begin
          state_nxt = ST_DATA;
        end else begin
          mreq.en   = 1'b1;
          mreq.addr = sum;
          k_nxt     = k_r + 3'd1;
        end
      end
      ST_DATA: begin
        mreq.en   = 1'b1;
        mreq.addr = (opc_r == OPC_MOV) ? a2 : a1;
        state_nxt = ST_DATB;
      end
      ST_DATB: begin
        case (opc_r)
          OPC_MOV: begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = a1;
            mreq.wdata = rdata;
            offs       = LEN_MOV;
            pc_nxt     = sum;
            state_nxt  = ST_DONE;
          end
          OPC_CMP: begin
            d1_nxt    = rdata;
            mreq.en   = 1'b1;
            mreq.addr = a2;
            state_nxt = ST_DATC;
          end
          default: begin
            pc_nxt    = (rdata != 8'd0) ? a2 : a3;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DATC: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = a3;
        mreq.wdata = {7'd0, d1_r < rdata};
        offs       = LEN_CMP;
        pc_nxt     = sum;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      pc_r    <= 16'd0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
    end
    k_r   <= k_nxt;
    opr_r <= opr_nxt;
    d1_r  <= d1_nxt;
    opc_r <= opc_nxt;
    rd_r  <= rd_nxt;
  end

  assign res_data.rd_byte      = rd_r;
  assign res_data.prog_counter = pc_r;
  assign res_data.is_halted    = halt_r;
  assign res_data.last_opcode  = opc_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> $stable(pc_r))
    else $error("pc moved while halted");

  a_pc_states: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FETCH && state_r != ST_DATB && state_r != ST_DATC) |=> $stable(pc_r))
    else $error("pc changed outside an update step");

  a_no_early_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_OPND || state_r == ST_DATA) |-> !(mreq.en && mreq.we))
    else $error("memory written before all operands were read");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!in_ready && !res_valid))
    else $error("channel active during clearing pass");

endmodule

@@ bench/vm_step_checker.sv @@
// Checker for the memory-to-memory machine: predicts each result and compares it.
module vm_step_checker import mtm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  mtm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  mtm_out_t out_data,
  output int       errors
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  mem_img [MEM_DEPTH];
  logic [15:0] pc_img;
  logic        halt_img;
  mtm_out_t    pending_results [$];
  int          fails = 0;

  assign errors = fails;

  function automatic int slot(logic [15:0] a);
    return int'(a) % MEM_DEPTH;
  endfunction

  // little-endian operand at byte offset off from pc, wrapping at 16 bits
  function automatic logic [15:0] operand_at(logic [15:0] off);
    logic [15:0] p;
    p = pc_img + off;
    return {mem_img[slot(p + 16'd1)], mem_img[slot(p)]};
  endfunction

  function automatic void run_instr(logic [7:0] opc);
    logic [15:0] a1, a2, a3;
    a1 = operand_at(16'd1);
    a2 = operand_at(16'd3);
    a3 = operand_at(16'd5);
    if (opc == OPC_MOV) begin
      mem_img[slot(a1)] = mem_img[slot(a2)];
      pc_img = pc_img + 16'(LEN_MOV);
    end else if (opc == OPC_CMP) begin
      mem_img[slot(a3)] = (mem_img[slot(a1)] < mem_img[slot(a2)]) ? 8'd1 : 8'd0;
      pc_img = pc_img + 16'(LEN_CMP);
    end else if (opc <= OPC_SKIP) begin
      pc_img = pc_img + 16'd1;
    end else if (opc == OPC_JNZ) begin
      pc_img = (mem_img[slot(a1)] != 8'd0) ? a2 : a3;
    end else if (opc <= OPC_HLTH) begin
      halt_img = 1'b1;
    end else if (opc == OPC_FC || opc == OPC_FE) begin
      pc_img = pc_img + 16'd5;
    end else if (opc == OPC_FD) begin
      pc_img = pc_img + 16'd7;
    end else begin
      pc_img = pc_img + 16'd3;
    end
  endfunction

  function automatic mtm_out_t predict_step(mtm_in_t it);
    mtm_out_t r;
    r = '0;
    case (it.op)
      OP_WR: mem_img[slot(it.mem_addr)] = it.wr_byte;
      OP_RD: r.rd_byte = mem_img[slot(it.mem_addr)];
      OP_EX: begin
        r.last_opcode = mem_img[slot(pc_img)];
        if (!halt_img) begin
          run_instr(r.last_opcode);
        end
      end
      default: ;
    endcase
    r.prog_counter = pc_img;
    r.is_halted    = halt_img;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    mtm_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_img[i] = STOP_CODE;
      pc_img   = '0;
      halt_img = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing pending, expected none, got %h",
                   $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("rd_byte", 16'(want.rd_byte), 16'(out_data.rd_byte));
          check_field("prog_counter", want.prog_counter, out_data.prog_counter);
          check_field("is_halted", 16'(want.is_halted), 16'(out_data.is_halted));
          check_field("last_opcode", 16'(want.last_opcode), 16'(out_data.last_opcode));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_step(in_data));
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for mem_to_mem_vm_step: clock, reset, stimulus, result sink and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtm_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int RANDOM_END  = 1820;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mtm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mtm_out_t out_data;
  int       errors;

  int          n_sent = 0;
  int          n_done = 0;
  logic [15:0] last_pc = '0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  mem_to_mem_vm_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  vm_step_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("mem_to_mem_vm_step regression: fail");
    $finish;
  end

  // results seen so far and the pc of the latest one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_done  <= n_done + 1;
      last_pc <= out_data.prog_counter;
    end
  end

  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(logic [1:0] op, logic [15:0] addr, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mtm_in_t'{op: op, mem_addr: addr, wr_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // drop valid and wait for every result, so last_pc is the machine's pc
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_done < n_sent);
  endtask

  task automatic issue_instr(logic [7:0] opc, logic [47:0] opnds, int n_opnd, bit fire);
    send(OP_WR, last_pc, opc);
    for (int k = 0; k < n_opnd; k++) begin
      send(OP_WR, last_pc + 16'(k + 1), opnds[k*8 +: 8]);
    end
    if (fire) begin
      send(OP_EX, 16'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_addr(logic [15:0] base);
    logic [15:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: a = base + 16'($urandom_range(7, 40));
      5, 6, 7:       a = 16'($urandom);
      8:             a = 16'($urandom_range(0, 15));
      default:       a = 16'hFFF0 + 16'($urandom_range(0, 15));
    endcase
    return a;
  endfunction

  initial begin : stimulus
    logic [7:0]  opc;
    logic [15:0] x1, x2, x3, a;
    int          kind, next_flip, hold_at;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, unused op, untouched byte
    send(OP_WR, 16'hFFFF, 8'hFF);
    send(OP_RD, 16'hFFFF, 8'h00);
    send(OP_NOP, 16'hFFFF, 8'hFF);
    send(OP_RD, 16'h0000, 8'h00);
    // JNZ at 0 tests its own opcode byte, jumps to the top of memory
    send(OP_WR, 16'h0000, OPC_JNZ);
    send(OP_WR, 16'h0001, 8'h00);
    send(OP_WR, 16'h0002, 8'h00);
    send(OP_WR, 16'h0003, 8'hFC);
    send(OP_WR, 16'h0004, 8'hFF);
    send(OP_EX, 16'h0000, 8'h00);
    // CMP_LT at 0xFFFC, operands wrap past the top and the result lands on 0
    send(OP_WR, 16'hFFFC, OPC_CMP);
    send(OP_WR, 16'hFFFD, 8'hFF);
    send(OP_WR, 16'hFFFE, 8'hFF);
    send(OP_WR, 16'hFFFF, 8'h00);
    send(OP_EX, 16'hFFFF, 8'hFF);
    // pc now 3, which holds 0xFC
    send(OP_EX, 16'h0000, 8'h00);
    // MOV at 8 overwrites its own first operand byte
    send(OP_WR, 16'h0008, OPC_MOV);
    send(OP_WR, 16'h0009, 8'h09);
    send(OP_WR, 16'h000A, 8'h00);
    send(OP_EX, 16'h0000, 8'h00);
    send(OP_RD, 16'h0009, 8'h00);
    send(OP_RD, 16'h0000, 8'h00);

    next_flip = n_sent;
    hold_at   = 300;
    while (n_sent < RANDOM_END) begin
      if (n_sent >= next_flip) begin
        no_idle   = ($urandom_range(0, 3) == 0);
        next_flip = n_sent + 150;
      end
      if (n_sent >= hold_at) begin
        hold_req = 1'b1;
        hold_at  = hold_at + 800;
        repeat (12) send(OP_WR, 16'($urandom), 8'($urandom));
      end
      kind = $urandom_range(0, 99);
      if (kind < 85 && kind >= 70) begin
        case ($urandom_range(0, 2))
          0:       send(OP_WR, 16'($urandom), 8'($urandom));
          1:       send(OP_RD, pick_addr(last_pc), 8'($urandom));
          default: send(OP_NOP, 16'($urandom), 8'($urandom));
        endcase
      end else begin
        settle();
        case ($urandom_range(0, 9))
          0, 1, 2: opc = OPC_MOV;
          3, 4:    opc = OPC_CMP;
          5:       opc = 8'($urandom_range(OPC_CMP + 1, OPC_SKIP));
          6, 7:    opc = OPC_JNZ;
          default: opc = OPC_FC + 8'($urandom_range(0, 3));
        endcase
        x1 = pick_addr(last_pc);
        x2 = pick_addr(last_pc);
        x3 = pick_addr(last_pc);
        if (kind < 70) begin
          if ($urandom_range(0, 1)) begin
            send(OP_WR, x1, ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
          end
          if ($urandom_range(0, 1)) begin
            send(OP_WR, x2, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
          end
          issue_instr(opc, {x3, x2, x1}, 6, 1'b1);
          if ($urandom_range(0, 3) == 0) begin
            send(OP_RD, (opc == OPC_CMP) ? x3 : x1, 8'($urandom));
          end
        end else begin
          // partial operands, or an instruction planted and never run
          issue_instr(opc, {x3, x2, x1}, $urandom_range(0, 5), 1'($urandom_range(0, 1)));
        end
      end
    end

    // stop opcode, then execute, access and idle while halted
    no_idle = 1'b0;
    settle();
    send(OP_WR, last_pc, 8'($urandom_range(OPC_HLTL, OPC_HLTH)));
    send(OP_EX, 16'($urandom), 8'($urandom));
    send(OP_EX, 16'($urandom), 8'($urandom));
    a = 16'($urandom);
    send(OP_WR, a, 8'($urandom));
    send(OP_RD, a, 8'($urandom));
    send(OP_NOP, 16'($urandom), 8'($urandom));
    send(OP_EX, 16'($urandom), 8'($urandom));

    settle();
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("mem_to_mem_vm_step regression: pass");
    end else begin
      $display("mem_to_mem_vm_step regression: fail");
    end
    $finish;
  end

endmodule
